FILE: design/hmc_pkg.sv
// Shared constants, types and elaboration-time helpers for the Hamming codec.
package hmc_pkg;

    localparam int WORD_W            = 63;
    localparam int SYN_W             = 6;
    localparam int DBITS_W           = 6;
    localparam int MAX_DATA_BITS_DEF = 57;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;
    localparam int DBITS_RESET       = 4;

    // Register index of data_bits in the configuration map
    localparam logic REG_DATA_BITS = 1'b0;

    typedef enum logic {
        ACT_ENCODE = 1'b0,
        ACT_DECODE = 1'b1
    } action_t;

    // Codeword length n = d + r, r least with 2^r >= d + r + 1
    function automatic logic [SYN_W-1:0] code_len(input logic [DBITS_W-1:0] d);
        int r;
        r = 0;
        for (int i = 0; i < 7; i++)
        begin
            if ((1 << r) < int'(d) + r + 1)
                r++;
        end
        return SYN_W'(int'(d) + r);
    endfunction

    // True for parity positions (powers of two)
    function automatic bit is_pow2(input int p);
        return (p & (p - 1)) == 0;
    endfunction

    // Data bit index carried at non-parity position p
    function automatic int data_index(input int p);
        int cnt;
        cnt = 0;
        for (int i = 0; i < 7; i++)
        begin
            if ((1 << i) < p)
                cnt++;
        end
        return p - 1 - cnt;
    endfunction

    // Positions whose index has bit b set
    function automatic logic [WORD_W-1:0] check_sel(input int b);
        logic [WORD_W-1:0] sel;
        sel = '0;
        for (int p = 1; p <= WORD_W; p++)
        begin
            sel[p-1] = ((p >> b) & 1) == 1;
        end
        return sel;
    endfunction

endpackage

FILE: design/hmc_if.sv
// Valid/ready channel interfaces for codec requests and results.
interface hmc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [hmc_pkg::WORD_W-1:0]  word;

    modport source (output valid, action, word, input ready);
    modport sink   (input valid, action, word, output ready);
endinterface

interface hmc_out_if;
    logic                        valid;
    logic                        ready;
    logic [hmc_pkg::WORD_W-1:0]  code_word;
    logic [hmc_pkg::SYN_W-1:0]   syndrome;
    logic                        error_found;
    logic                        syndrome_out_of_range;

    modport source (output valid, code_word, syndrome, error_found, syndrome_out_of_range,
                    input ready);
    modport sink   (input valid, code_word, syndrome, error_found, syndrome_out_of_range,
                    output ready);
endinterface

FILE: design/hmc_syndrome.sv
// Parity check trees: XOR of the indices of all set codeword positions.
module hmc_syndrome
(
    input  logic [hmc_pkg::WORD_W-1:0] code,
    output logic [hmc_pkg::SYN_W-1:0]  syndrome
);

    for (genvar b = 0; b < hmc_pkg::SYN_W; b++)
    begin : g_check
        localparam logic [hmc_pkg::WORD_W-1:0] SEL = hmc_pkg::check_sel(b);
        assign syndrome[b] = ^(code & SEL);
    end

endmodule

FILE: design/hamming_codec.sv
// Top level of the pipelined Hamming single-error-correcting codec.
//
// Hamming SEC codec for d = 1..MAX_DATA_BITS data bits (register data_bits at
// byte address 0, reset 4; 0 acts as 1, values above MAX_DATA_BITS saturate).
// Position p of a codeword is bit p-1; parity sits at power-of-two positions.
// action 0 encodes the low d bits of word; action 1 checks a codeword of n = d + r
// bits, flips the bit the syndrome names, or flags syndrome_out_of_range when
// the syndrome points past n and leaves the word uncorrected. A new transaction
// is taken every cycle unless backpressure stalls the pipeline. Three register
// stages: scatter and mask, then the six parity check trees, then parity
// insertion or correction into the output register. A transaction passes the
// stage 1, stage 2 and output registers in that order before its result is
// valid. Backpressure stalls the pipeline stage by stage, and empty stages fill
// while a result waits. Change data_bits only while no transaction is in flight.
module hamming_codec #(
    parameter int MAX_DATA_BITS = hmc_pkg::MAX_DATA_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    hmc_in_if.sink                            in_ch,
    hmc_out_if.source                         out_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hmc_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [hmc_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [hmc_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int W = hmc_pkg::WORD_W;
    localparam int S = hmc_pkg::SYN_W;
    localparam int D = hmc_pkg::DBITS_W;

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [D-1:0] data_bits_reg;
    logic         cfg_wr;

    assign pready = 1'b1;
    // Bit 2 selects the register slot; only slot zero exists
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == hmc_pkg::REG_DATA_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_bits_reg <= D'(hmc_pkg::DBITS_RESET);
        else if (cfg_wr)
            data_bits_reg <= pwdata[D-1:0];
    end

    assign prdata = (paddr[2] == hmc_pkg::REG_DATA_BITS)
                  ? {{(hmc_pkg::CFG_DATA_W-D){1'b0}}, data_bits_reg} : '0;

    // ---------------------------------------------------------------
    // Code geometry: clamp d, derive n and the position mask
    // ---------------------------------------------------------------
    logic [D-1:0] d_eff;
    logic [S-1:0] n_len;
    logic [W-1:0] pos_mask;

    always_comb
    begin
        if (data_bits_reg == '0)
            d_eff = D'(1);
        else if (data_bits_reg > D'(MAX_DATA_BITS))
            d_eff = D'(MAX_DATA_BITS);
        else
            d_eff = data_bits_reg;
        n_len = hmc_pkg::code_len(d_eff);
    end

    for (genvar i = 0; i < W; i++)
    begin : g_mask
        assign pos_mask[i] = n_len >= S'(i + 1);
    end

    // ---------------------------------------------------------------
    // Stage enables: a stage advances when empty or when its successor advances
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, out_v_reg;
    logic en1, en2, out_en;

    assign out_en      = !out_v_reg || out_ch.ready;
    assign en2         = !v2_reg || out_en;
    assign en1         = !v1_reg || en2;
    assign in_ch.ready = en1;

    // ---------------------------------------------------------------
    // Stage 1: scatter data onto non-parity positions or pass the word; mask to n
    // ---------------------------------------------------------------
    logic [W-1:0] scatter;
    logic [W-1:0] cw1_reg, cw1_next;
    logic         act1_reg;

    for (genvar p = 1; p <= W; p++)
    begin : g_scatter
        if (hmc_pkg::is_pow2(p))
        begin : g_par
            assign scatter[p-1] = 1'b0;
        end
        else
        begin : g_dat
            localparam int K = hmc_pkg::data_index(p);
            assign scatter[p-1] = in_ch.word[K];
        end
    end

    assign cw1_next = ((in_ch.action == hmc_pkg::ACT_ENCODE) ? scatter : in_ch.word) & pos_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en1)
            v1_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_ch.valid)
        begin
            cw1_reg  <= cw1_next;
            act1_reg <= in_ch.action;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: parity check trees
    // ---------------------------------------------------------------
    logic [S-1:0] syn2_next, syn2_reg;
    logic [W-1:0] cw2_reg;
    logic         act2_reg;

    hmc_syndrome u_syndrome
    (
        .code     (cw1_reg),
        .syndrome (syn2_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && v1_reg)
        begin
            cw2_reg  <= cw1_reg;
            syn2_reg <= syn2_next;
            act2_reg <= act1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: insert parity (encode) or correct (decode) into output register
    // ---------------------------------------------------------------
    logic [W-1:0] par_bits, flip;
    logic [W-1:0] code_reg, code_next;
    logic [S-1:0] syn_reg, syn_next;
    logic         err_reg, err_next;
    logic         oor_reg, oor_next;

    always_comb
    begin
        par_bits = '0;
        for (int b = 0; b < S; b++)
        begin
            par_bits[(1 << b) - 1] = syn2_reg[b];
        end
    end

    for (genvar i = 0; i < W; i++)
    begin : g_flip
        assign flip[i] = (syn2_reg == S'(i + 1)) && pos_mask[i];
    end

    always_comb
    begin
        if (act2_reg == hmc_pkg::ACT_ENCODE)
        begin
            code_next = (cw2_reg | par_bits) & pos_mask;
            syn_next  = '0;
            err_next  = 1'b0;
            oor_next  = 1'b0;
        end
        else
        begin
            code_next = cw2_reg ^ flip;
            syn_next  = syn2_reg;
            err_next  = syn2_reg != '0;
            oor_next  = syn2_reg > n_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (out_en)
            out_v_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_en && v2_reg)
        begin
            code_reg <= code_next;
            syn_reg  <= syn_next;
            err_reg  <= err_next;
            oor_reg  <= oor_next;
        end
    end

    assign out_ch.valid                 = out_v_reg;
    assign out_ch.code_word             = code_reg;
    assign out_ch.syndrome              = syn_reg;
    assign out_ch.error_found           = err_reg;
    assign out_ch.syndrome_out_of_range = oor_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Hold a blocked middle stage: no transaction dropped under backpressure
    a_hold_stage2: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !en2 |=> v2_reg)
        else $error("stage 2 transaction lost while stalled");

    // Encode results never report an error
    a_encode_clean: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && out_en && (act2_reg == hmc_pkg::ACT_ENCODE)
        |=> out_v_reg && (syn_reg == '0) && !err_reg && !oor_reg)
        else $error("encode transaction produced error flags");

    // An out-of-range syndrome is always a detected error
    a_oor_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_v_reg && oor_reg |-> err_reg && (syn_reg != '0))
        else $error("out-of-range flag without error");

endmodule
